[rtl/core/grid_repulsion_move_planner_macros.svh]
// Assertion macros shared by the checker files of the move planner.
// Include this header by its bare file name.
`ifndef GRID_REPULSION_MOVE_PLANNER_MACROS_SVH
`define GRID_REPULSION_MOVE_PLANNER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define GRMP_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("grmp check failed");
// Next-cycle implication checked outside reset.
`define GRMP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("grmp check failed");
`endif

[rtl/core/grmp_pkg.sv]
// Shared types, constants and arithmetic helpers of the move planner.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package grmp_pkg;
    localparam int MapDimDefault = 64;
    localparam logic [16:0] InvSqrt2Q16 = 17'd46341;
    localparam logic signed [18:0] ForceMax = 19'sd262143;
    localparam logic signed [18:0] ForceMin = -19'sd262144;

    localparam logic [2:0] RegMapColumns = 3'd0;
    localparam logic [2:0] RegMapRows = 3'd1;
    localparam logic [2:0] RegForceGain = 3'd2;
    localparam logic [2:0] RegSenseRadius = 3'd3;
    localparam logic [2:0] RegForceThreshold = 3'd4;

    localparam logic ActWrite = 1'b0;
    localparam logic ActQuery = 1'b1;

    // Ray direction: -1, 0 or +1 per axis, in the order of the eight rays.
    function automatic logic signed [1:0] ray_dx(input logic [2:0] d);
        case (d)
            3'd0, 3'd1: ray_dx = 2'sd0;
            3'd2, 3'd4, 3'd6: ray_dx = -2'sd1;
            default: ray_dx = 2'sd1;
        endcase
    endfunction

    function automatic logic signed [1:0] ray_dy(input logic [2:0] d);
        case (d)
            3'd0, 3'd4, 3'd5: ray_dy = -2'sd1;
            3'd2, 3'd3: ray_dy = 2'sd0;
            default: ray_dy = 2'sd1;
        endcase
    endfunction

    // floor(s*sqrt2)^2 for s in 1..44, as a table (larger s never passes the radius test).
    function automatic logic [12:0] diag_sq(input logic [5:0] s);
        logic [12:0] m;
        logic [12:0] t;
        t = 13'd0;
        for (m = 13'd0; m < 13'd90; m++) begin
            if (m * m <= {1'b0, 12'(2 * s * s)}) t = m;
        end
        diag_sq = 13'(t * t);
    endfunction
endpackage
`default_nettype wire

[rtl/core/grmp_div.sv]
// Restoring divider: one quotient bit per cycle, shared by all ray hits.
// Depends on nothing but the clock and reset.
`timescale 1ns / 1ps
`default_nettype none
module grmp_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [32:0] i_num,
    input  wire logic [28:0] i_den,
    output logic             o_done,
    output logic [32:0]      o_quot
);
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [32:0] r_q;
    logic [32:0] r_rem;
    logic [28:0] r_den;
    logic [33:0] w_trial;

    assign w_trial = {r_rem, r_q[32]} - {5'd0, r_den};
    assign o_quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 6'd33;
                r_q <= i_num;
                r_rem <= '0;
                r_den <= i_den;
            end else if (r_busy) begin
                if (!w_trial[33]) begin
                    r_rem <= w_trial[32:0];
                    r_q <= {r_q[31:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[31:0], r_q[32]};
                    r_q <= {r_q[31:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

[rtl/core/grid_repulsion_move_planner.sv]
// Top level of the occupancy-grid move planner: map memory, ray walk, force sum.
// Depends on grmp_pkg and grmp_div.
//
// Usage: registers are written over the APB port (byte address 4*index). An item is
// taken when start is high and busy is low. A write item (action 0) stores one map
// cell and gives no result; the next beat can follow in the next cycle.
// A query item (action 1) walks eight rays from the robot cell. Each cell read on a ray
// passes the address, memory read and check steps, and each ray closes in a step of its
// own; a ray that hits runs the shared divider first. Saturation, the squares and the
// compares follow after the last ray; busy stays high through the whole query.
// The result shows on the move and force ports for one cycle with o_valid high, in the
// first cycle that busy is low again; the receiver cannot stall it.
// After reset the map is cleared by a pass over all MAP_DIM*MAP_DIM cells (4096 at the
// default), one cell per cycle, during which busy stays high; register writes are
// taken throughout.
`timescale 1ns / 1ps
`default_nettype none
module grid_repulsion_move_planner #(
    parameter int MAP_DIM = grmp_pkg::MapDimDefault
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [4:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_action,
    input  wire logic [5:0]        i_cell_x,
    input  wire logic [5:0]        i_cell_y,
    input  wire logic              i_cell_occupied,
    input  wire logic [5:0]        i_robot_x,
    input  wire logic [5:0]        i_robot_y,
    output logic                   o_valid,
    output logic signed [1:0]      o_move_x,
    output logic signed [1:0]      o_move_y,
    output logic signed [18:0]     o_force_x,
    output logic signed [18:0]     o_force_y
);
    import grmp_pkg::*;

    localparam int CW = $clog2(MAP_DIM);
    localparam int AW = 2 * CW;
    localparam int Depth = MAP_DIM * MAP_DIM;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_STEP, S_READ, S_CHECK, S_DIV, S_NEXT,
        S_SQ, S_CMP, S_OUT
    } t_state;

    t_state r_state;
    logic [6:0]  r_cols, r_rows;
    logic [15:0] r_gain;
    logic [5:0]  r_radius;
    logic [17:0] r_thr;

    logic        r_mem [Depth];
    logic        r_rd;
    logic [AW-1:0] r_clr;

    logic [5:0]  r_rx, r_ry;
    logic [2:0]  r_dir;
    logic [5:0]  r_s;
    logic signed [8:0] r_cx, r_cy;
    logic signed [23:0] r_fx, r_fy;
    logic signed [18:0] r_sfx, r_sfy;
    logic [37:0] r_ax2, r_ay2, r_t2;

    logic        w_div_start, w_div_done;
    logic [32:0] w_num, w_quot;
    logic [28:0] w_den;
    logic        w_cfg_wr, w_diag, w_in_map, w_in_radius, w_last;
    logic signed [8:0] w_ncx, w_ncy;
    logic [7:0]  w_cols_eff, w_rows_eff;
    logic [18:0] w_ax, w_ay;
    logic [12:0] w_dsq;

    assign pready = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[4:2])
            RegMapColumns: prdata = {25'd0, r_cols};
            RegMapRows: prdata = {25'd0, r_rows};
            RegForceGain: prdata = {16'd0, r_gain};
            RegSenseRadius: prdata = {26'd0, r_radius};
            RegForceThreshold: prdata = {14'd0, r_thr};
            default: prdata = 32'd0;
        endcase
    end

    assign w_diag = (ray_dx(r_dir) != 2'sd0) && (ray_dy(r_dir) != 2'sd0);
    assign w_ncx = $signed({3'd0, r_rx}) + 9'(ray_dx(r_dir)) * $signed({3'd0, r_s});
    assign w_ncy = $signed({3'd0, r_ry}) + 9'(ray_dy(r_dir)) * $signed({3'd0, r_s});
    assign w_cols_eff = (MAP_DIM > 127 || {1'b0, r_cols} < 8'(MAP_DIM)) ? {1'b0, r_cols}
                                                                        : 8'(MAP_DIM);
    assign w_rows_eff = (MAP_DIM > 127 || {1'b0, r_rows} < 8'(MAP_DIM)) ? {1'b0, r_rows}
                                                                        : 8'(MAP_DIM);
    assign w_in_radius = w_diag ? (13'(2 * r_s * r_s) <= 13'(r_radius * r_radius))
                                : (r_s <= r_radius);
    assign w_in_map = !w_ncx[8] && !w_ncy[8] && (w_ncx[7:0] < w_cols_eff)
                      && (w_ncy[7:0] < w_rows_eff);
    assign w_last = (r_dir == 3'd7);
    assign w_dsq = diag_sq(r_s);

    // Diagonal hits scale the gain by 1/sqrt2 in Q16 and divide by 65536*d^2.
    assign w_num = w_diag ? 33'(r_gain * InvSqrt2Q16) : {17'd0, r_gain};
    assign w_den = w_diag ? {w_dsq[12:0], 16'd0} : 29'(r_s * r_s);
    assign w_div_start = (r_state == S_CHECK) && r_rd;

    grmp_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(w_num), .i_den(w_den), .o_done(w_div_done), .o_quot(w_quot)
    );

    assign w_ax = r_sfx[18] ? 19'(-r_sfx) : 19'(r_sfx);
    assign w_ay = r_sfy[18] ? 19'(-r_sfy) : 19'(r_sfy);
    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (start && !busy && i_action == ActWrite) begin
            if (32'(i_cell_x) < 32'(MAP_DIM) && 32'(i_cell_y) < 32'(MAP_DIM))
                r_mem[{CW'(i_cell_y), CW'(i_cell_x)}] <= i_cell_occupied;
        end else if (r_state == S_CLEAR) begin
            r_mem[r_clr] <= 1'b0;
        end
        r_rd <= r_mem[{w_ncy[CW-1:0], w_ncx[CW-1:0]}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_cols <= 7'd64;
            r_rows <= 7'd64;
            r_gain <= 16'd256;
            r_radius <= 6'd5;
            r_thr <= 18'd0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (w_cfg_wr) begin
                case (paddr[4:2])
                    RegMapColumns: r_cols <= pwdata[6:0];
                    RegMapRows: r_rows <= pwdata[6:0];
                    RegForceGain: r_gain <= pwdata[15:0];
                    RegSenseRadius: r_radius <= pwdata[5:0];
                    RegForceThreshold: r_thr <= pwdata[17:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(Depth - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (start && i_action == ActQuery) begin
                        r_rx <= i_robot_x;
                        r_ry <= i_robot_y;
                        r_dir <= 3'd0;
                        r_s <= 6'd1;
                        r_fx <= '0;
                        r_fy <= '0;
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (w_in_radius && w_in_map) r_state <= S_READ;
                    else r_state <= S_NEXT;
                end
                S_READ: r_state <= S_CHECK;
                S_CHECK: begin
                    if (r_rd) r_state <= S_DIV;
                    else if (r_s == 6'd63) r_state <= S_NEXT;
                    else begin
                        r_s <= r_s + 6'd1;
                        r_state <= S_STEP;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_fx <= r_fx - 24'(ray_dx(r_dir)) * $signed({1'b0, w_quot[17:0]});
                        r_fy <= r_fy - 24'(ray_dy(r_dir)) * $signed({1'b0, w_quot[17:0]});
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    r_dir <= r_dir + 3'd1;
                    r_s <= 6'd1;
                    if (w_last) begin
                        r_sfx <= (r_fx > 24'(ForceMax)) ? ForceMax :
                                 (r_fx < 24'(ForceMin)) ? ForceMin : r_fx[18:0];
                        r_sfy <= (r_fy > 24'(ForceMax)) ? ForceMax :
                                 (r_fy < 24'(ForceMin)) ? ForceMin : r_fy[18:0];
                        r_state <= S_SQ;
                    end else r_state <= S_STEP;
                end
                S_SQ: begin
                    r_ax2 <= 38'(w_ax * w_ax);
                    r_ay2 <= 38'(w_ay * w_ay);
                    r_t2 <= 38'(r_thr * r_thr);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    o_force_x <= r_sfx;
                    o_force_y <= r_sfy;
                    if (({1'b0, r_ax2} + {1'b0, r_ay2}) < {1'b0, r_t2}) begin
                        o_move_x <= 2'sd0;
                        o_move_y <= 2'sd0;
                    end else if (40'(3 * r_ay2) < 40'(r_ax2)) begin
                        o_move_x <= r_sfx[18] ? -2'sd1 : 2'sd1;
                        o_move_y <= 2'sd0;
                    end else if (40'(r_ay2) < 40'(3 * r_ax2)) begin
                        o_move_x <= r_sfx[18] ? -2'sd1 : 2'sd1;
                        o_move_y <= r_sfy[18] ? -2'sd1 : 2'sd1;
                    end else begin
                        o_move_x <= 2'sd0;
                        o_move_y <= r_sfy[18] ? -2'sd1 : 2'sd1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[rtl/core/grmp_checker.sv]
// Port-level checker of the move planner, bound to the top level.
// Depends on grid_repulsion_move_planner_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "grid_repulsion_move_planner_macros.svh"
module grmp_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              i_action,
    input wire logic              o_valid,
    input wire logic signed [1:0] o_move_x,
    input wire logic signed [1:0] o_move_y
);
    // A result comes only in the cycle right after the block was busy.
    `GRMP_ASSERT_IMP(a_valid_busy, i_clk, i_rst_n, o_valid, $past(busy) && !busy)
    // A query beat makes the block busy in the next cycle.
    `GRMP_ASSERT_NEXT(a_query_busy, i_clk, i_rst_n, start && !busy && i_action, busy)
    // A write beat leaves the block free in the next cycle.
    `GRMP_ASSERT_NEXT(a_write_free, i_clk, i_rst_n, start && !busy && !i_action, !busy)
    // A move step is never the unused code.
    `GRMP_ASSERT_IMP(a_move_code, i_clk, i_rst_n, o_valid, o_move_x != 2'b10 && o_move_y != 2'b10)
endmodule
bind grid_repulsion_move_planner grmp_checker u_grmp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_action(i_action),
    .o_valid(o_valid), .o_move_x(o_move_x), .o_move_y(o_move_y)
);
`default_nettype wire
